@@ hdl/periodic_timer_bank_priority_queue_macros.svh @@
// Assertion macros shared by the timer bank modules.
`ifndef PERIODIC_TIMER_BANK_PRIORITY_QUEUE_MACROS_SVH
`define PERIODIC_TIMER_BANK_PRIORITY_QUEUE_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define PTBPQ_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PTBPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ptbpq_pkg.sv @@
`timescale 1ns / 1ps
package ptbpq_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W = $clog2(MAX_RESULTS);

    localparam logic [3:0] ACT_TICK = 4'd0;
    localparam logic [3:0] ACT_ADD = 4'd1;
    localparam logic [3:0] ACT_REMOVE = 4'd2;
    localparam logic [3:0] ACT_STOP = 4'd3;
    localparam logic [3:0] ACT_START = 4'd4;
    localparam logic [3:0] ACT_SET_IVAL = 4'd5;
    localparam logic [3:0] ACT_POP = 4'd6;
    localparam logic [3:0] ACT_REMOVE_ALL = 4'd7;
    localparam logic [3:0] ACT_HALT = 4'd8;
    localparam logic [3:0] ACT_CLEAR_QUEUE = 4'd9;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_Q_EMPTY = 2'd2;
    localparam logic [1:0] ST_Q_DROP = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK_RD,
        S_WALK_UPD,
        S_FIND,
        S_START_RD,
        S_START_LD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic mem_rd;
        logic use_slot;
        logic tick_upd;
        logic find;
        logic start_ld;
        logic idx_inc;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [3:0] act;
        logic       running;
        logic       idx_last;
        logic       idx_free;
        logic       out_free;
        logic       emit_last;
    } stat_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] which;
        logic       fired;
        logic       popped;
        logic [7:0] plevel;
    } res_t;

endpackage

@@ hdl/ptbpq_ctrl.sv @@
`timescale 1ns / 1ps
`include "periodic_timer_bank_priority_queue_macros.svh"
module ptbpq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ptbpq_pkg::stat_t stat,
    output ptbpq_pkg::cmd_t  cmd
);

    ptbpq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptbpq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ptbpq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ptbpq_pkg::S_EXEC;
                end
            end
            ptbpq_pkg::S_EXEC: begin
                case (stat.act)
                    ptbpq_pkg::ACT_TICK: begin
                        state_next = stat.running ? ptbpq_pkg::S_WALK_RD : ptbpq_pkg::S_OUT;
                    end
                    ptbpq_pkg::ACT_ADD: begin
                        state_next = ptbpq_pkg::S_FIND;
                    end
                    ptbpq_pkg::ACT_START: begin
                        state_next = ptbpq_pkg::S_START_RD;
                    end
                    default: begin
                        cmd.exec = 1'b1;
                        cmd.use_slot = 1'b1;
                        state_next = ptbpq_pkg::S_OUT;
                    end
                endcase
            end
            ptbpq_pkg::S_WALK_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ptbpq_pkg::S_WALK_UPD;
            end
            ptbpq_pkg::S_WALK_UPD: begin
                cmd.tick_upd = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next = stat.idx_last ? ptbpq_pkg::S_OUT : ptbpq_pkg::S_WALK_RD;
            end
            ptbpq_pkg::S_FIND: begin
                cmd.find = 1'b1;
                if (stat.idx_free || stat.idx_last) begin
                    state_next = ptbpq_pkg::S_OUT;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ptbpq_pkg::S_START_RD: begin
                cmd.mem_rd = 1'b1;
                cmd.use_slot = 1'b1;
                state_next = ptbpq_pkg::S_START_LD;
            end
            ptbpq_pkg::S_START_LD: begin
                cmd.start_ld = 1'b1;
                cmd.use_slot = 1'b1;
                state_next = ptbpq_pkg::S_OUT;
            end
            ptbpq_pkg::S_OUT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last) begin
                        state_next = ptbpq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = ptbpq_pkg::S_IDLE;
            end
        endcase
    end

    `PTBPQ_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_valid && s_ready, state_reg == ptbpq_pkg::S_EXEC, "accepted command not executed")
    `PTBPQ_ASSERT_NEXT(a_walk_pair, aclk, aresetn, state_reg == ptbpq_pkg::S_WALK_RD, state_reg == ptbpq_pkg::S_WALK_UPD, "slot read not followed by update")
    `PTBPQ_ASSERT_ALWAYS(a_emit_free, aclk, aresetn, !cmd.emit || stat.out_free, "result loaded over a waiting transfer")

endmodule

@@ hdl/ptbpq_dp.sv @@
`timescale 1ns / 1ps
`include "periodic_timer_bank_priority_queue_macros.svh"
module ptbpq_dp #(
    parameter int TIMER_SLOTS = ptbpq_pkg::TIMER_SLOTS_DEF,
    parameter int QUEUE_DEPTH = ptbpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ptbpq_pkg::cmd_t  cmd,
    output ptbpq_pkg::stat_t stat,
    input  logic [3:0]       s_action,
    input  logic [3:0]       s_slot,
    input  logic [30:0]      s_interval,
    input  logic [7:0]       s_level,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [3:0]       m_which,
    output logic             m_fired,
    output logic             m_popped,
    output logic [7:0]       m_popped_level,
    output logic [4:0]       m_queued,
    output logic             m_slot_free,
    output logic             m_ticking,
    output logic             m_last
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int RCW = ptbpq_pkg::RES_CNT_W;
    localparam int RIW = ptbpq_pkg::RES_IDX_W;

    logic [3:0]  act_reg;
    logic [3:0]  slot_reg;
    logic [30:0] ival_reg;
    logic [7:0]  lvl_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [RIW-1:0] rd_idx_reg;
    logic [RCW-1:0] res_n_reg;
    logic running_reg;
    logic [TIMER_SLOTS-1:0] assigned_reg;
    logic [TIMER_SLOTS-1:0] armed_reg;

    logic [7:0]  lvl_mem [TIMER_SLOTS];
    logic [30:0] rel_mem [TIMER_SLOTS];
    logic [30:0] cnt_mem [TIMER_SLOTS];
    logic [7:0]  lvl_rd_reg;
    logic [30:0] rel_rd_reg;
    logic [30:0] cnt_rd_reg;

    logic [3:0] q_slot_reg [QUEUE_DEPTH];
    logic [7:0] q_lvl_reg [QUEUE_DEPTH];
    logic [QW-1:0] fill_reg;

    ptbpq_pkg::res_t buf_reg [ptbpq_pkg::MAX_RESULTS];

    logic m_valid_reg;
    ptbpq_pkg::res_t m_res_reg;
    logic [4:0] m_queued_reg;
    logic m_slot_free_reg, m_ticking_reg, m_last_reg;

    logic [IDX_W+3:0] slot_w, idx_w;
    logic [IDX_W-1:0] slot_addr, addr;
    logic slot_ok;
    logic [3:0] idx_which;
    logic idx_act, idx_expire, slot_startable;
    logic push_en;
    ptbpq_pkg::res_t push_res;
    logic enq_en, deq_en, q_clr;
    logic [QUEUE_DEPTH-1:0] gt;
    logic cnt_we, rel_we, lvl_we;
    logic [30:0] cnt_wd;
    logic [RCW-1:0] n_eff;
    ptbpq_pkg::res_t emit_res;
    logic [QW+4:0] fill_w;

    assign slot_w = (IDX_W + 4)'(slot_reg);
    assign slot_addr = slot_w[IDX_W-1:0];
    assign slot_ok = slot_w < (IDX_W + 4)'(TIMER_SLOTS);
    assign addr = cmd.use_slot ? slot_addr : idx_reg;
    assign idx_w = (IDX_W + 4)'(idx_reg);
    assign idx_which = idx_w[3:0];
    assign idx_act = assigned_reg[idx_reg] && armed_reg[idx_reg];
    assign idx_expire = cnt_rd_reg <= 31'd1;
    assign slot_startable = slot_ok && assigned_reg[slot_addr] && !armed_reg[slot_addr];

    always_comb begin
        push_en = 1'b0;
        push_res = '0;
        enq_en = 1'b0;
        deq_en = 1'b0;
        q_clr = 1'b0;
        cnt_we = 1'b0;
        rel_we = 1'b0;
        lvl_we = 1'b0;
        cnt_wd = ival_reg;
        if (cmd.tick_upd && idx_act) begin
            cnt_we = 1'b1;
            cnt_wd = idx_expire ? rel_rd_reg : cnt_rd_reg - 31'd1;
            if (idx_expire) begin
                if (lvl_rd_reg == 8'd0) begin
                    push_en = 1'b1;
                    push_res.which = idx_which;
                    push_res.fired = 1'b1;
                end else if (fill_reg < QW'(QUEUE_DEPTH)) begin
                    enq_en = 1'b1;
                end else begin
                    push_en = 1'b1;
                    push_res.status = ptbpq_pkg::ST_Q_DROP;
                    push_res.which = idx_which;
                end
            end
        end
        if (cmd.find) begin
            if (!assigned_reg[idx_reg]) begin
                cnt_we = 1'b1;
                rel_we = 1'b1;
                lvl_we = 1'b1;
                push_en = 1'b1;
                push_res.which = idx_which;
            end else if (stat.idx_last) begin
                push_en = 1'b1;
                push_res.status = ptbpq_pkg::ST_NO_SLOT;
            end
        end
        if (cmd.start_ld && slot_startable) begin
            cnt_we = 1'b1;
            cnt_wd = rel_rd_reg;
        end
        if (cmd.exec) begin
            case (act_reg)
                ptbpq_pkg::ACT_SET_IVAL: begin
                    cnt_we = slot_ok;
                    rel_we = slot_ok;
                end
                ptbpq_pkg::ACT_POP: begin
                    push_en = 1'b1;
                    if (fill_reg == '0) begin
                        push_res.status = ptbpq_pkg::ST_Q_EMPTY;
                    end else begin
                        deq_en = 1'b1;
                        push_res.which = q_slot_reg[0];
                        push_res.popped = 1'b1;
                        push_res.plevel = q_lvl_reg[0];
                    end
                end
                ptbpq_pkg::ACT_CLEAR_QUEUE: begin
                    q_clr = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= s_action;
            slot_reg <= s_slot;
            ival_reg <= s_interval;
            lvl_reg <= s_level;
        end
        if (cnt_we) begin
            cnt_mem[addr] <= cnt_wd;
        end
        if (rel_we) begin
            rel_mem[addr] <= ival_reg;
        end
        if (lvl_we) begin
            lvl_mem[addr] <= lvl_reg;
        end
        if (cmd.mem_rd) begin
            cnt_rd_reg <= cnt_mem[addr];
            rel_rd_reg <= rel_mem[addr];
            lvl_rd_reg <= lvl_mem[addr];
        end
        if (push_en && res_n_reg < RCW'(ptbpq_pkg::MAX_RESULTS)) begin
            buf_reg[res_n_reg[RIW-1:0]] <= push_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            rd_idx_reg <= '0;
            res_n_reg <= '0;
            running_reg <= 1'b0;
            assigned_reg <= '0;
            armed_reg <= '0;
        end else begin
            if (cmd.load) begin
                idx_reg <= '0;
                rd_idx_reg <= '0;
                res_n_reg <= '0;
            end else begin
                if (cmd.idx_inc && !stat.idx_last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cmd.emit) begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (push_en && res_n_reg < RCW'(ptbpq_pkg::MAX_RESULTS)) begin
                    res_n_reg <= res_n_reg + 1'b1;
                end
            end
            if (cmd.find && !assigned_reg[idx_reg]) begin
                assigned_reg[idx_reg] <= 1'b1;
                armed_reg[idx_reg] <= 1'b1;
                running_reg <= 1'b1;
            end
            if (cmd.start_ld && slot_startable) begin
                armed_reg[slot_addr] <= 1'b1;
                running_reg <= 1'b1;
            end
            if (cmd.exec) begin
                case (act_reg)
                    ptbpq_pkg::ACT_REMOVE: begin
                        if (slot_ok) begin
                            assigned_reg[slot_addr] <= 1'b0;
                            armed_reg[slot_addr] <= 1'b0;
                        end
                    end
                    ptbpq_pkg::ACT_STOP: begin
                        if (slot_ok) begin
                            armed_reg[slot_addr] <= 1'b0;
                        end
                    end
                    ptbpq_pkg::ACT_SET_IVAL: begin
                        if (slot_startable) begin
                            armed_reg[slot_addr] <= 1'b1;
                            running_reg <= 1'b1;
                        end
                    end
                    ptbpq_pkg::ACT_REMOVE_ALL: begin
                        assigned_reg <= '0;
                        armed_reg <= '0;
                        running_reg <= 1'b0;
                    end
                    ptbpq_pkg::ACT_HALT: begin
                        running_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // The queue stays sorted: entries above the new level move up one place.
    always_comb begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            gt[j] = (QW'(j) < fill_reg) && (q_lvl_reg[j] > lvl_rd_reg);
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            if (enq_en) begin
                if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
                    q_slot_reg[j] <= q_slot_reg[(j > 0) ? j - 1 : 0];
                    q_lvl_reg[j] <= q_lvl_reg[(j > 0) ? j - 1 : 0];
                end else if ((j == 0 || !gt[(j > 0) ? j - 1 : 0])
                             && (gt[j] || QW'(j) == fill_reg)) begin
                    q_slot_reg[j] <= idx_which;
                    q_lvl_reg[j] <= lvl_rd_reg;
                end
            end else if (deq_en && j < QUEUE_DEPTH - 1) begin
                q_slot_reg[j] <= q_slot_reg[(j < QUEUE_DEPTH - 1) ? j + 1 : j];
                q_lvl_reg[j] <= q_lvl_reg[(j < QUEUE_DEPTH - 1) ? j + 1 : j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (q_clr) begin
            fill_reg <= '0;
        end else if (enq_en) begin
            fill_reg <= fill_reg + 1'b1;
        end else if (deq_en) begin
            fill_reg <= fill_reg - 1'b1;
        end
    end

    assign n_eff = (res_n_reg == '0) ? RCW'(1) : res_n_reg;
    assign emit_res = (res_n_reg == '0) ? '0 : buf_reg[rd_idx_reg];
    assign fill_w = (QW + 5)'(fill_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_res_reg <= emit_res;
            m_queued_reg <= fill_w[4:0];
            m_slot_free_reg <= !(&assigned_reg);
            m_ticking_reg <= running_reg;
            m_last_reg <= stat.emit_last;
        end
    end

    assign stat.act = act_reg;
    assign stat.running = running_reg;
    assign stat.idx_last = idx_reg == IDX_W'(TIMER_SLOTS - 1);
    assign stat.idx_free = !assigned_reg[idx_reg];
    assign stat.out_free = !m_valid_reg || m_ready;
    assign stat.emit_last = (RCW'(rd_idx_reg) + RCW'(1)) >= n_eff;

    assign m_valid = m_valid_reg;
    assign m_status = m_res_reg.status;
    assign m_which = m_res_reg.which;
    assign m_fired = m_res_reg.fired;
    assign m_popped = m_res_reg.popped;
    assign m_popped_level = m_res_reg.plevel;
    assign m_queued = m_queued_reg;
    assign m_slot_free = m_slot_free_reg;
    assign m_ticking = m_ticking_reg;
    assign m_last = m_last_reg;

    `PTBPQ_ASSERT_ALWAYS(a_fill_range, aclk, aresetn, fill_reg <= QW'(QUEUE_DEPTH), "queue fill above depth")
    `PTBPQ_ASSERT_ALWAYS(a_res_range, aclk, aresetn, res_n_reg <= RCW'(ptbpq_pkg::MAX_RESULTS), "result count above buffer size")
    `PTBPQ_ASSERT_ALWAYS(a_armed_assigned, aclk, aresetn, (armed_reg & ~assigned_reg) == '0, "unassigned slot is armed")

endmodule

@@ hdl/periodic_timer_bank_priority_queue.sv @@
`timescale 1ns / 1ps
// Channel   Ports              Carries
// input     s_valid, s_ready   one command: action, slot, interval, level
// result    m_valid, m_ready   one to sixteen results per command, last on the final one
//
// A tick walks every slot, reading each and then updating it, but only while running is set.
// An add scans for the first free slot, one slot per cycle; a start reads the slot, then loads it.
// Results are delivered one per cycle from a result buffer while m_ready is high.
// The next command is accepted once the last result sits in the output register.
// Reset is synchronous and active low; it clears the slots, the queue fill and running.
module periodic_timer_bank_priority_queue #(
    parameter int TIMER_SLOTS = ptbpq_pkg::TIMER_SLOTS_DEF,
    parameter int QUEUE_DEPTH = ptbpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_action,
    input  logic [3:0]  s_slot,
    input  logic [30:0] s_interval,
    input  logic [7:0]  s_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_which,
    output logic        m_fired,
    output logic        m_popped,
    output logic [7:0]  m_popped_level,
    output logic [4:0]  m_queued,
    output logic        m_slot_free,
    output logic        m_ticking,
    output logic        m_last
);

    ptbpq_pkg::cmd_t  cmd;
    ptbpq_pkg::stat_t stat;

    ptbpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptbpq_dp #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_action       (s_action),
        .s_slot         (s_slot),
        .s_interval     (s_interval),
        .s_level        (s_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_which        (m_which),
        .m_fired        (m_fired),
        .m_popped       (m_popped),
        .m_popped_level (m_popped_level),
        .m_queued       (m_queued),
        .m_slot_free    (m_slot_free),
        .m_ticking      (m_ticking),
        .m_last         (m_last)
    );

endmodule

@@ verif/periodic_timer_bank_priority_queue_tb.sv @@
`timescale 1ns / 1ps
module periodic_timer_bank_priority_queue_tb;

    localparam int NSLOT = 16;
    localparam int QDEPTH = 16;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_action;
    logic [3:0]  s_slot;
    logic [30:0] s_interval;
    logic [7:0]  s_level;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [3:0]  m_which;
    logic        m_fired;
    logic        m_popped;
    logic [7:0]  m_popped_level;
    logic [4:0]  m_queued;
    logic        m_slot_free;
    logic        m_ticking;
    logic        m_last;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] which;
        logic       fired;
        logic       popped;
        logic [7:0] plevel;
        logic [4:0] queued;
        logic       slot_free;
        logic       ticking;
        logic       last;
    } timer_result_t;

    periodic_timer_bank_priority_queue DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_action(s_action), .s_slot(s_slot),
        .s_interval(s_interval), .s_level(s_level),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_which(m_which), .m_fired(m_fired),
        .m_popped(m_popped), .m_popped_level(m_popped_level),
        .m_queued(m_queued), .m_slot_free(m_slot_free),
        .m_ticking(m_ticking), .m_last(m_last)
    );

    // Shadow copy of the timer bank.
    logic [30:0] shadow_reload [NSLOT];
    logic [30:0] shadow_count [NSLOT];
    logic        shadow_assigned [NSLOT];
    logic        shadow_armed [NSLOT];
    logic [7:0]  shadow_level [NSLOT];
    logic        shadow_running;
    logic [3:0]  ready_slot [$];
    logic [7:0]  ready_level [$];

    timer_result_t pending_results [$];
    int errors;
    int sent_items;
    int checked_results;
    int fire_count;
    int drop_count;
    int pop_count;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic timer_result_t blank_result();
        timer_result_t r;
        r = '0;
        r.status = ptbpq_pkg::ST_OK;
        return r;
    endfunction

    function automatic timer_result_t make_result(logic [1:0] st, logic [3:0] w,
                                                  logic f, logic p, logic [7:0] pl);
        timer_result_t r;
        r = '0;
        r.status = st;
        r.which = w;
        r.fired = f;
        r.popped = p;
        r.plevel = pl;
        return r;
    endfunction

    function automatic void reset_bank();
        for (int i = 0; i < NSLOT; i++) begin
            shadow_reload[i] = '0;
            shadow_count[i] = '0;
            shadow_assigned[i] = 1'b0;
            shadow_armed[i] = 1'b0;
            shadow_level[i] = '0;
        end
        shadow_running = 1'b0;
        ready_slot.delete();
        ready_level.delete();
    endfunction

    function automatic void clear_timer(int i);
        shadow_assigned[i] = 1'b0;
        shadow_armed[i] = 1'b0;
        shadow_reload[i] = '0;
        shadow_count[i] = '0;
        shadow_level[i] = '0;
    endfunction

    function automatic void arm_timer(int i);
        if (shadow_assigned[i] && !shadow_armed[i]) begin
            shadow_armed[i] = 1'b1;
            shadow_count[i] = shadow_reload[i];
            shadow_running = 1'b1;
        end
    endfunction

    function automatic bit insert_ready(logic [3:0] s, logic [7:0] l);
        int pos;
        if (ready_level.size() >= QDEPTH) return 0;
        pos = ready_level.size();
        while (pos > 0 && ready_level[pos-1] > l) pos--;
        ready_slot.insert(pos, s);
        ready_level.insert(pos, l);
        return 1;
    endfunction

    // Applies one command to the shadow bank and queues the results it yields.
    function automatic void predict_command(logic [3:0] act, logic [3:0] sl,
                                            logic [30:0] iv, logic [7:0] lv);
        timer_result_t res [$];
        bit any_free;
        int i;
        case (act)
            ptbpq_pkg::ACT_TICK: begin
                if (shadow_running) begin
                    for (i = 0; i < NSLOT; i++) begin
                        if (!shadow_assigned[i] || !shadow_armed[i]) continue;
                        if (shadow_count[i] > 31'd1) begin
                            shadow_count[i] = shadow_count[i] - 31'd1;
                            continue;
                        end
                        shadow_count[i] = shadow_reload[i];
                        if (shadow_level[i] == 8'd0) begin
                            if (res.size() < ptbpq_pkg::MAX_RESULTS)
                                res.push_back(make_result(ptbpq_pkg::ST_OK, i[3:0], 1'b1,
                                                          1'b0, 8'd0));
                            fire_count++;
                        end else if (!insert_ready(i[3:0], shadow_level[i])) begin
                            if (res.size() < ptbpq_pkg::MAX_RESULTS)
                                res.push_back(make_result(ptbpq_pkg::ST_Q_DROP, i[3:0],
                                                          1'b0, 1'b0, 8'd0));
                            drop_count++;
                        end
                    end
                end
            end
            ptbpq_pkg::ACT_ADD: begin
                for (i = 0; i < NSLOT; i++)
                    if (!shadow_assigned[i]) break;
                if (i < NSLOT) begin
                    shadow_assigned[i] = 1'b1;
                    shadow_armed[i] = 1'b1;
                    shadow_reload[i] = iv;
                    shadow_count[i] = iv;
                    shadow_level[i] = lv;
                    shadow_running = 1'b1;
                    res.push_back(make_result(ptbpq_pkg::ST_OK, i[3:0], 1'b0, 1'b0, 8'd0));
                end else begin
                    res.push_back(make_result(ptbpq_pkg::ST_NO_SLOT, 4'd0, 1'b0, 1'b0,
                                              8'd0));
                end
            end
            ptbpq_pkg::ACT_REMOVE: clear_timer(sl);
            ptbpq_pkg::ACT_STOP: shadow_armed[sl] = 1'b0;
            ptbpq_pkg::ACT_START: arm_timer(sl);
            ptbpq_pkg::ACT_SET_IVAL: begin
                shadow_reload[sl] = iv;
                shadow_count[sl] = iv;
                if (!shadow_armed[sl]) arm_timer(sl);
            end
            ptbpq_pkg::ACT_POP: begin
                if (ready_slot.size() == 0) begin
                    res.push_back(make_result(ptbpq_pkg::ST_Q_EMPTY, 4'd0, 1'b0, 1'b0,
                                              8'd0));
                end else begin
                    res.push_back(make_result(ptbpq_pkg::ST_OK, ready_slot[0], 1'b0, 1'b1,
                                              ready_level[0]));
                    void'(ready_slot.pop_front());
                    void'(ready_level.pop_front());
                    pop_count++;
                end
            end
            ptbpq_pkg::ACT_REMOVE_ALL: begin
                shadow_running = 1'b0;
                for (i = 0; i < NSLOT; i++) clear_timer(i);
            end
            ptbpq_pkg::ACT_HALT: shadow_running = 1'b0;
            ptbpq_pkg::ACT_CLEAR_QUEUE: begin
                ready_slot.delete();
                ready_level.delete();
            end
            default: ;
        endcase
        if (res.size() == 0) res.push_back(blank_result());
        any_free = 0;
        for (i = 0; i < NSLOT; i++)
            if (!shadow_assigned[i]) any_free = 1;
        foreach (res[k]) begin
            res[k].queued = 5'(ready_slot.size());
            res[k].slot_free = any_free;
            res[k].ticking = shadow_running;
            res[k].last = (k == res.size() - 1);
            pending_results.push_back(res[k]);
        end
    endfunction

    task automatic send_command(logic [3:0] act, logic [3:0] sl, logic [30:0] iv,
                                logic [7:0] lv);
        @(negedge aclk);
        s_action <= act;
        s_slot <= sl;
        s_interval <= iv;
        s_level <= lv;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_command(act, sl, iv, lv);
        sent_items++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    int burst_left;

    task automatic send_paced(logic [3:0] act, logic [3:0] sl, logic [30:0] iv,
                              logic [7:0] lv);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_command(act, sl, iv, lv);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic test_directed();
        send_command(ptbpq_pkg::ACT_POP, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_TICK, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_ADD, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_ADD, 4'd0, 31'd1, 8'd255);
        send_command(ptbpq_pkg::ACT_ADD, 4'd0, 31'h7FFF_FFFF, 8'd3);
        send_command(ptbpq_pkg::ACT_ADD, 4'd0, 31'd2, 8'd3);
        send_command(ptbpq_pkg::ACT_TICK, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_TICK, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_POP, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_STOP, 4'd1, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_START, 4'd1, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_SET_IVAL, 4'd2, 31'd1, 8'd0);
        send_command(ptbpq_pkg::ACT_SET_IVAL, 4'd9, 31'd4, 8'd0);
        send_command(ptbpq_pkg::ACT_HALT, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_TICK, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_START, 4'd2, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_REMOVE, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_TICK, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_CLEAR_QUEUE, 4'd0, 31'd0, 8'd0);
        send_command(4'd10, 4'd15, 31'h7FFF_FFFF, 8'hFF);
        send_command(4'd15, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_REMOVE_ALL, 4'd0, 31'd0, 8'd0);
    endtask

    task automatic test_full_bank();
        for (int i = 0; i < 17; i++)
            send_command(ptbpq_pkg::ACT_ADD, 4'd0, 31'd0, (i % 3 == 0) ? 8'd0 : 8'(i));
        repeat (3) send_command(ptbpq_pkg::ACT_TICK, 4'd0, 31'd0, 8'd0);
        drain_results();
        repeat (17) send_command(ptbpq_pkg::ACT_POP, 4'd0, 31'd0, 8'd0);
        send_command(ptbpq_pkg::ACT_REMOVE_ALL, 4'd0, 31'd0, 8'd0);
    endtask

    task automatic test_random(int count);
        int r;
        logic [3:0] act;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) act = ptbpq_pkg::ACT_TICK;
            else if (r < 55) act = ptbpq_pkg::ACT_ADD;
            else if (r < 70) act = ptbpq_pkg::ACT_POP;
            else if (r < 95) act = 4'($urandom_range(2, 9));
            else act = 4'($urandom_range(10, 15));
            send_paced(act, 4'($urandom), ($urandom_range(0, 9) == 0) ? 31'($urandom)
                       : 31'($urandom_range(0, 5)),
                       ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
            if (n == count / 2) drain_results();
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 20) m_ready <= ($urandom_range(0, 3) == 0);
        else m_ready <= ($urandom_range(0, 9) != 0);
    end

    always @(posedge aclk) begin
        timer_result_t got;
        timer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_which, m_fired, m_popped, m_popped_level, m_queued,
                   m_slot_free, m_ticking, m_last};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                checked_results++;
                if (got.status !== want.status || got.which !== want.which ||
                    got.fired !== want.fired || got.popped !== want.popped ||
                    got.plevel !== want.plevel || got.queued !== want.queued ||
                    got.slot_free !== want.slot_free || got.ticking !== want.ticking ||
                    got.last !== want.last) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("periodic_timer_bank_priority_queue test failed");
        $finish;
    end

    initial begin
        aclk = 1'b0;
        errors = 0;
        sent_items = 0;
        checked_results = 0;
        fire_count = 0;
        drop_count = 0;
        pop_count = 0;
        burst_left = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = '0;
        s_slot = '0;
        s_interval = '0;
        s_level = '0;
        reset_bank();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full_bank();
        test_random(360);
        drain_results();
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
        end
        $display("Sent %0d commands, checked %0d results.", sent_items, checked_results);
        $display("Saw %0d immediate expiries, %0d drops and %0d pops.",
                 fire_count, drop_count, pop_count);
        if (errors == 0) begin
            $display("periodic_timer_bank_priority_queue test passed");
        end else begin
            $display("periodic_timer_bank_priority_queue test failed");
        end
        $finish;
    end
endmodule
